// File: rtl/core/rf_code_packet_deframer_defines.svh
// ----------------------------------------------------------------------------
// Radio code packet deframer: assertion macros
// Concurrent assertion helpers shared by the deframer RTL. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RF_CODE_PACKET_DEFRAMER_DEFINES_SVH
`define RF_CODE_PACKET_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define RFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deframer assertion failed");

// Condition must never be true at a clock edge outside reset.
`define RFD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("deframer forbidden condition seen");

`else

`define RFD_ASSERT(lbl, clk, rst_n, prop)
`define RFD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: rtl/core/rfd_pkg.sv
// ----------------------------------------------------------------------------
// Radio code packet deframer package
// Types, status codes, register indexes and reset constants of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

    localparam int unsigned MaxPayloadDefault = 16;

    localparam logic [15:0] DedupeWindowReset = 16'd200;
    localparam logic [7:0]  SyncValueReset    = 8'hAA;
    localparam logic [7:0]  CrcPoly           = 8'h07;

    // Register index, taken from paddr[2].
    localparam logic REG_DEDUPE_WINDOW = 1'b0;
    localparam logic REG_SYNC_VALUE    = 1'b1;

    typedef enum logic [1:0] {
        PH_SYNC,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [3:0] {
        STS_ZERO      = 4'd0,
        STS_DUPLICATE = 4'd1,
        STS_NO_SYNC   = 4'd2,
        STS_SYNC_OK   = 4'd3,
        STS_BAD_LEN   = 4'd4,
        STS_HEADER_OK = 4'd5,
        STS_EMPTY_OK  = 4'd6,
        STS_CRC_FAIL  = 4'd7,
        STS_PARTIAL   = 4'd8,
        STS_PACKET_OK = 4'd9
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CRC,
        ST_FINISH,
        ST_RESULT,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/rf_code_packet_deframer.sv
// ----------------------------------------------------------------------------
// Radio code packet deframer
// Filters repeated radio codes, reassembles sync/header/payload packets from
// three bytes per code, checks a bit-serial CRC-8 and emits payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (i_code, i_timestamp) are taken on i_in_valid && o_in_ready.
//   One input beat is worked on at a time; o_in_ready is high only while the
//   block is idle. Each beat gives one result beat, except a packet that ends
//   with a good CRC and a nonzero length, which gives one beat per payload
//   byte, with o_last on the final one.
//   Zero, duplicate, sync and bad length codes go from the decide state
//   straight to the result register. A header code runs the CRC over three
//   bytes (sequence, type, length), one bit per cycle. A payload code runs
//   the CRC over each gathered byte, up to three per code. A good packet
//   then emits its bytes one at a time, each through a payload RAM read
//   state and an output load state.
//   The result register decouples the sides: a waiting result does not keep
//   the next input beat out, but a new result waits while the receiver
//   stalls, and so does the input side behind it.
//   Reset is synchronous and active low; it returns the deframer to waiting
//   for sync and restores the register defaults (window 200 ms, sync 0xAA).
// ----------------------------------------------------------------------------
`default_nettype none
`include "rf_code_packet_deframer_defines.svh"

module rf_code_packet_deframer
    import rfd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD_BYTES = MaxPayloadDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_code,
    input  wire logic [31:0] i_timestamp,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_status,
    output logic [7:0]       o_sequence_res,
    output logic [7:0]       o_packet_type,
    output logic [4:0]       o_length,
    output logic [7:0]       o_computed_crc,
    output logic [7:0]       o_received_crc,
    output logic [4:0]       o_progress,
    output logic [7:0]       o_data_byte,
    output logic             o_data_valid,
    output logic             o_last
);

    localparam int unsigned LW = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int unsigned AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
    localparam logic [7:0]  MaxLen8 = 8'(MAX_PAYLOAD_BYTES);

    // Control and deframer state
    t_state        r_state,       n_state;
    t_phase        r_phase,       n_phase;
    logic [31:0]   r_prev_code,   n_prev_code;
    logic [31:0]   r_prev_time,   n_prev_time;
    logic [7:0]    r_seq,         n_seq;
    logic [7:0]    r_type,        n_type;
    logic [LW-1:0] r_len,         n_len;
    logic [7:0]    r_crc_exp,     n_crc_exp;
    logic [LW-1:0] r_count,       n_count;
    logic [7:0]    r_crc,         n_crc;
    logic [15:0]   r_window,      n_window;
    logic [7:0]    r_sync,        n_sync;
    logic          r_out_valid,   n_out_valid;

    // Working registers
    logic [31:0]   r_code,        n_code;
    logic [31:0]   r_ts,          n_ts;
    logic [23:0]   r_sh,          n_sh;
    logic [4:0]    r_bits,        n_bits;
    logic          r_hdr_mode,    n_hdr_mode;
    t_status       r_pend_status, n_pend_status;
    logic [7:0]    r_pend_crc,    n_pend_crc;
    logic [LW-1:0] r_idx,         n_idx;

    // Result register
    t_status       r_o_status,    n_o_status;
    logic [7:0]    r_o_seq,       n_o_seq;
    logic [7:0]    r_o_type,      n_o_type;
    logic [4:0]    r_o_len,       n_o_len;
    logic [7:0]    r_o_ccrc,      n_o_ccrc;
    logic [7:0]    r_o_rcrc,      n_o_rcrc;
    logic [4:0]    r_o_prog,      n_o_prog;
    logic [7:0]    r_o_data,      n_o_data;
    logic          r_o_dv,        n_o_dv;
    logic          r_o_last,      n_o_last;

    // Payload RAM
    logic [7:0]    r_store [MAX_PAYLOAD_BYTES];
    logic [7:0]    r_rd;
    logic          w_we;
    logic          w_re;

    logic          w_cfg_wr;
    logic          w_out_free;
    logic          w_dup;
    logic [31:0]   w_age;
    logic [7:0]    w_b0;
    logic [7:0]    w_b1;
    logic [7:0]    w_b2;
    logic [7:0]    w_rem8;
    logic [1:0]    w_nb;
    logic          w_fb;
    logic [LW-1:0] w_idx_next;
    logic          w_emit_last;

    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite;
    assign prdata      = (paddr[2] == REG_SYNC_VALUE) ? {24'd0, r_sync} : {16'd0, r_window};

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign w_b0        = r_code[23:16];
    assign w_b1        = r_code[15:8];
    assign w_b2        = r_code[7:0];
    assign w_age       = r_ts - r_prev_time;
    assign w_dup       = (r_code == r_prev_code) && (w_age < {16'd0, r_window});

    // Bytes a payload code contributes: the first always, then up to the length.
    assign w_rem8      = 8'(r_len - r_count);
    assign w_nb        = (w_rem8 >= 8'd3) ? 2'd3 : w_rem8[1:0];

    assign w_fb        = r_crc[7] ^ r_sh[23];
    assign w_idx_next  = r_idx + 1'b1;
    assign w_emit_last = (w_idx_next == r_len);

    assign w_re        = (r_state == ST_EMIT_RD);

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_prev_code   = r_prev_code;
        n_prev_time   = r_prev_time;
        n_seq         = r_seq;
        n_type        = r_type;
        n_len         = r_len;
        n_crc_exp     = r_crc_exp;
        n_count       = r_count;
        n_crc         = r_crc;
        n_window      = r_window;
        n_sync        = r_sync;
        n_code        = r_code;
        n_ts          = r_ts;
        n_sh          = r_sh;
        n_bits        = r_bits;
        n_hdr_mode    = r_hdr_mode;
        n_pend_status = r_pend_status;
        n_pend_crc    = r_pend_crc;
        n_idx         = r_idx;
        n_o_status    = r_o_status;
        n_o_seq       = r_o_seq;
        n_o_type      = r_o_type;
        n_o_len       = r_o_len;
        n_o_ccrc      = r_o_ccrc;
        n_o_rcrc      = r_o_rcrc;
        n_o_prog      = r_o_prog;
        n_o_data      = r_o_data;
        n_o_dv        = r_o_dv;
        n_o_last      = r_o_last;
        n_out_valid   = r_out_valid && !i_out_ready;
        w_we          = 1'b0;

        if (w_cfg_wr) begin
            if (paddr[2] == REG_SYNC_VALUE) begin
                n_sync = pwdata[7:0];
            end else begin
                n_window = pwdata[15:0];
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_code  = i_code;
                    n_ts    = i_timestamp;
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                n_pend_crc = 8'd0;
                n_state    = ST_RESULT;
                if (r_code == 32'd0) begin
                    n_pend_status = STS_ZERO;
                end else if (w_dup) begin
                    n_prev_time   = r_ts;
                    n_pend_status = STS_DUPLICATE;
                end else begin
                    n_prev_code = r_code;
                    n_prev_time = r_ts;
                    case (r_phase)
                        PH_HEADER: begin
                            n_phase = PH_SYNC;
                            if (w_b0 > MaxLen8) begin
                                n_pend_status = STS_BAD_LEN;
                            end else begin
                                n_len      = w_b0[LW-1:0];
                                n_crc_exp  = w_b1;
                                n_count    = '0;
                                n_crc      = 8'd0;
                                n_sh       = {r_seq, r_type, w_b0};
                                n_bits     = 5'd24;
                                n_hdr_mode = 1'b1;
                                n_state    = ST_CRC;
                            end
                        end
                        PH_PAYLOAD: begin
                            n_sh       = {w_b0, w_b1, w_b2};
                            n_bits     = {w_nb, 3'b000};
                            n_hdr_mode = 1'b0;
                            n_state    = ST_CRC;
                        end
                        default: begin
                            n_phase = PH_SYNC;
                            if (w_b0 == r_sync) begin
                                n_seq         = w_b1;
                                n_type        = w_b2;
                                n_phase       = PH_HEADER;
                                n_pend_status = STS_SYNC_OK;
                            end else begin
                                n_pend_status = STS_NO_SYNC;
                            end
                        end
                    endcase
                end
            end

            ST_CRC: begin
                // MSB-first CRC-8, one message bit per cycle.
                n_crc  = {r_crc[6:0], 1'b0} ^ (w_fb ? CrcPoly : 8'd0);
                n_sh   = {r_sh[22:0], 1'b0};
                n_bits = r_bits - 5'd1;
                // Payload bytes are stored as they start through the CRC.
                if (!r_hdr_mode && (r_bits[2:0] == 3'd0)) begin
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                end
                if (r_bits == 5'd1) begin
                    n_state = ST_FINISH;
                end
            end

            ST_FINISH: begin
                n_pend_crc = 8'd0;
                n_state    = ST_RESULT;
                if (r_hdr_mode) begin
                    if (r_len == '0) begin
                        n_pend_status = (r_crc == r_crc_exp) ? STS_EMPTY_OK : STS_CRC_FAIL;
                        n_pend_crc    = r_crc;
                    end else begin
                        n_phase       = PH_PAYLOAD;
                        n_pend_status = STS_HEADER_OK;
                    end
                end else if (r_count < r_len) begin
                    n_pend_status = STS_PARTIAL;
                end else begin
                    n_phase = PH_SYNC;
                    if (r_crc != r_crc_exp) begin
                        n_pend_status = STS_CRC_FAIL;
                        n_pend_crc    = r_crc;
                    end else begin
                        n_idx   = '0;
                        n_state = ST_EMIT_RD;
                    end
                end
            end

            ST_RESULT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_pend_status;
                    n_o_seq     = r_seq;
                    n_o_type    = r_type;
                    n_o_len     = 5'(r_len);
                    n_o_ccrc    = r_pend_crc;
                    n_o_rcrc    = r_crc_exp;
                    n_o_prog    = 5'(r_count);
                    n_o_data    = 8'd0;
                    n_o_dv      = 1'b0;
                    n_o_last    = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            ST_EMIT_RD: begin
                n_state = ST_EMIT_WR;
            end

            ST_EMIT_WR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = STS_PACKET_OK;
                    n_o_seq     = r_seq;
                    n_o_type    = r_type;
                    n_o_len     = 5'(r_len);
                    n_o_ccrc    = r_crc;
                    n_o_rcrc    = r_crc_exp;
                    n_o_prog    = 5'(r_idx);
                    n_o_data    = r_rd;
                    n_o_dv      = 1'b1;
                    n_o_last    = w_emit_last;
                    n_idx       = w_idx_next;
                    n_state     = w_emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_SYNC;
            r_prev_code <= 32'd0;
            r_prev_time <= 32'd0;
            r_seq       <= 8'd0;
            r_type      <= 8'd0;
            r_len       <= '0;
            r_crc_exp   <= 8'd0;
            r_count     <= '0;
            r_crc       <= 8'd0;
            r_window    <= DedupeWindowReset;
            r_sync      <= SyncValueReset;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_prev_code <= n_prev_code;
            r_prev_time <= n_prev_time;
            r_seq       <= n_seq;
            r_type      <= n_type;
            r_len       <= n_len;
            r_crc_exp   <= n_crc_exp;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_window    <= n_window;
            r_sync      <= n_sync;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code        <= n_code;
        r_ts          <= n_ts;
        r_sh          <= n_sh;
        r_bits        <= n_bits;
        r_hdr_mode    <= n_hdr_mode;
        r_pend_status <= n_pend_status;
        r_pend_crc    <= n_pend_crc;
        r_idx         <= n_idx;
        r_o_status    <= n_o_status;
        r_o_seq       <= n_o_seq;
        r_o_type      <= n_o_type;
        r_o_len       <= n_o_len;
        r_o_ccrc      <= n_o_ccrc;
        r_o_rcrc      <= n_o_rcrc;
        r_o_prog      <= n_o_prog;
        r_o_data      <= n_o_data;
        r_o_dv        <= n_o_dv;
        r_o_last      <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[r_count[AW-1:0]] <= r_sh[23:16];
        end
        if (w_re) begin
            r_rd <= r_store[r_idx[AW-1:0]];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_sequence_res = r_o_seq;
    assign o_packet_type  = r_o_type;
    assign o_length       = r_o_len;
    assign o_computed_crc = r_o_ccrc;
    assign o_received_crc = r_o_rcrc;
    assign o_progress     = r_o_prog;
    assign o_data_byte    = r_o_data;
    assign o_data_valid   = r_o_dv;
    assign o_last         = r_o_last;

    // A beat taken at the input drops o_in_ready in the following cycle.
    `RFD_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    // Between codes of a packet the gathered count stays below the length.
    `RFD_ASSERT(a_count_below_len, i_clk, i_rst_n, (r_phase == PH_PAYLOAD && r_state == ST_IDLE) |-> (r_count < r_len))
    // Emission never runs past the declared payload length.
    `RFD_ASSERT_NEVER(a_emit_in_range, i_clk, i_rst_n, (r_state == ST_EMIT_WR) && (r_idx >= r_len))

endmodule

`default_nettype wire
